[src/spnf_pkg.sv]
// Shared types and constants of the servo pulse normalizer frame block.
`timescale 1ns / 1ps
`default_nettype none

package spnf_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_CENTRE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_HYST   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ENDPOINT_DELTA = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STARTUP_TICKS = 2'd3;

  localparam logic [11:0] PULSE_CENTRE_RST   = 12'd1500;
  localparam logic [7:0]  SWITCH_HYST_RST    = 8'd5;
  localparam logic [9:0]  ENDPOINT_DELTA_RST = 10'd200;
  localparam logic [7:0]  STARTUP_TICKS_RST  = 8'd20;

  // Frame layout
  localparam int unsigned FRAME_BYTES  = 4;
  localparam int unsigned BYTE_IDX_W   = $clog2(FRAME_BYTES);
  localparam logic [7:0]  FRAME_HEADER = 8'h87;
  localparam logic [7:0]  STARTUP_FLAG = 8'h10;

  // Pulse limits in microseconds
  localparam logic [15:0] PULSE_MIN = 16'd600;
  localparam logic [15:0] PULSE_MAX = 16'd2500;
  localparam logic [15:0] CLAMP_LO  = 16'd800;
  localparam logic [15:0] CLAMP_HI  = 16'd2300;
  localparam logic [6:0]  PCT_SCALE = 7'd101;
  localparam logic [7:0]  PCT_MAX   = 8'd100;
  localparam int unsigned QUO_BITS  = 7;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [11:0] pulse_centre;
    logic [7:0]  switch_hyst;
    logic [9:0]  endpoint_delta;
    logic [7:0]  startup_ticks;
  } cfg_t;

  // One classified tick, front to back
  typedef struct packed {
    logic        normal;
    logic [15:0] steer_us;
    logic [15:0] throttle_us;
    logic        sw;
  } tick_cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CAL,
    B_PREP,
    B_SETUP,
    B_DIV,
    B_FIN,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

[src/spnf_queue.sv]
// Small register queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module spnf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/spnf_front.sv]
// Input side: timer conversion, startup gating and the channel three switch.
`timescale 1ns / 1ps
`default_nettype none

module spnf_front
  import spnf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        queue_full,
  output logic             cmd_push,
  output tick_cmd_t        cmd
);

  logic [7:0]  warmup_cnt;
  logic        switch_on;
  logic        switch_next;
  logic        accept;
  logic        normal;
  logic [15:0] aux_us;
  logic signed [17:0] aux_s;
  logic signed [17:0] sw_lo;
  logic signed [17:0] sw_hi;

  // (0xffff - t) * 3 / 4, with 0xffff - t being ~t
  function automatic logic [15:0] timer_to_us(input logic [15:0] t);
    logic [17:0] sum;
    sum = {2'b00, ~t} + {1'b0, ~t, 1'b0};
    return sum[17:2];
  endfunction

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign normal   = s_tuser && (warmup_cnt >= cfg.startup_ticks);

  assign aux_us = timer_to_us(s_tdata[47:32]);
  assign aux_s  = $signed({2'b00, aux_us});
  assign sw_lo  = $signed({6'd0, cfg.pulse_centre}) - $signed({10'd0, cfg.switch_hyst});
  assign sw_hi  = $signed({6'd0, cfg.pulse_centre}) + $signed({10'd0, cfg.switch_hyst});

  always_comb begin
    switch_next = switch_on;
    if (switch_on) begin
      if (aux_s < sw_lo) begin
        switch_next = 1'b0;
      end
    end else begin
      if (aux_s > sw_hi) begin
        switch_next = 1'b1;
      end
    end
  end

  assign cmd_push        = accept;
  assign cmd.normal      = normal;
  assign cmd.steer_us    = timer_to_us(s_tdata[15:0]);
  assign cmd.throttle_us = timer_to_us(s_tdata[31:16]);
  assign cmd.sw          = switch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_cnt <= '0;
      switch_on  <= 1'b0;
    end else if (accept) begin
      if (normal) begin
        switch_on <= switch_next;
      end else if (warmup_cnt < cfg.startup_ticks) begin
        warmup_cnt <= warmup_cnt + 8'd1;
      end
    end
  end

endmodule

`default_nettype wire

[src/spnf_back.sv]
// Output side: calibration, endpoint tracking, percent division and frame beats.
`timescale 1ns / 1ps
`default_nettype none

module spnf_back
  import spnf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [9:0] endpoint_delta,
  input  wire logic       cmd_valid,
  input  wire tick_cmd_t  cmd,
  output logic            cmd_pop,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);

  back_state_t state;
  back_state_t state_next;

  logic        calibrated;
  logic [15:0] centre_us    [2];
  logic [15:0] left_end_us  [2];
  logic [15:0] right_end_us [2];
  logic [7:0]  pct          [2];

  tick_cmd_t   cur;
  logic        ch;
  logic        neg;
  logic [15:0] diff;
  logic [15:0] den;
  logic [22:0] rem;
  logic [QUO_BITS-1:0] quo;
  logic [2:0]  bit_cnt;
  logic [BYTE_IDX_W-1:0] byte_idx;

  // per-channel prep
  logic [15:0] p_us;
  logic [15:0] p_cl;
  logic [15:0] c_us;
  logic        p_out;
  logic [15:0] e_us;
  logic [16:0] den_w;
  logic [23:0] trial;
  logic        out_free;
  logic        load_out;
  logic [7:0]  beat_data;
  logic        last_ch;

  assign p_us  = ch ? cur.throttle_us : cur.steer_us;
  assign c_us  = centre_us[ch];
  assign p_out = (p_us < PULSE_MIN) || (p_us > PULSE_MAX);
  assign p_cl  = (p_us < CLAMP_LO) ? CLAMP_LO : ((p_us > CLAMP_HI) ? CLAMP_HI : p_us);
  assign e_us  = neg ? left_end_us[ch] : right_end_us[ch];
  assign den_w = neg ? ({1'b0, c_us} - {1'b0, e_us}) : ({1'b0, e_us} - {1'b0, c_us});
  assign trial = {1'b0, rem} - ({8'd0, den} << bit_cnt);
  assign last_ch = ch;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (byte_idx)
      BYTE_IDX_W'(0): beat_data = FRAME_HEADER;
      BYTE_IDX_W'(1): beat_data = pct[0];
      BYTE_IDX_W'(2): beat_data = pct[1];
      default:        beat_data = cur.normal ? {7'd0, cur.sw} : STARTUP_FLAG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (!cmd.normal) begin
            state_next = B_EMIT;
          end else if (!calibrated) begin
            state_next = B_CAL;
          end else begin
            state_next = B_PREP;
          end
        end
      end
      B_CAL: state_next = B_PREP;
      B_PREP: begin
        if (p_out || (p_cl == c_us)) begin
          state_next = last_ch ? B_EMIT : B_PREP;
        end else begin
          state_next = B_SETUP;
        end
      end
      B_SETUP: begin
        if (den_w[16] || (den_w == '0) || ({1'b0, diff} >= den_w)) begin
          state_next = last_ch ? B_EMIT : B_PREP;
        end else begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (bit_cnt == 3'd0) begin
          state_next = B_FIN;
        end
      end
      B_FIN: state_next = last_ch ? B_EMIT : B_PREP;
      B_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (byte_idx == BYTE_IDX_W'(FRAME_BYTES - 1)) begin
            state_next = B_IDLE;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated <= 1'b0;
      m_tvalid   <= 1'b0;
      byte_idx   <= '0;
      ch         <= 1'b0;
    end else begin
      if (state == B_CAL) begin
        calibrated <= 1'b1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
        byte_idx <= byte_idx + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == B_IDLE) begin
        ch <= 1'b0;
      end else if (state_next == B_PREP && state != B_CAL && state != B_IDLE) begin
        ch <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= beat_data;
      m_tlast <= (byte_idx == BYTE_IDX_W'(FRAME_BYTES - 1));
    end
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cur    <= cmd;
          pct[0] <= '0;
          pct[1] <= '0;
        end
      end
      B_CAL: begin
        centre_us[0]    <= cur.steer_us;
        centre_us[1]    <= cur.throttle_us;
        left_end_us[0]  <= cur.steer_us - {6'd0, endpoint_delta};
        left_end_us[1]  <= cur.throttle_us - {6'd0, endpoint_delta};
        right_end_us[0] <= cur.steer_us + {6'd0, endpoint_delta};
        right_end_us[1] <= cur.throttle_us + {6'd0, endpoint_delta};
      end
      B_PREP: begin
        if (!p_out && (p_cl != c_us)) begin
          if (p_cl < c_us) begin
            if (p_cl < left_end_us[ch]) begin
              left_end_us[ch] <= p_cl;
            end
            neg  <= 1'b1;
            diff <= c_us - p_cl;
          end else begin
            if (p_cl > right_end_us[ch]) begin
              right_end_us[ch] <= p_cl;
            end
            neg  <= 1'b0;
            diff <= p_cl - c_us;
          end
        end
      end
      B_SETUP: begin
        den     <= den_w[15:0];
        rem     <= {7'd0, diff} * {16'd0, PCT_SCALE};
        quo     <= '0;
        bit_cnt <= 3'(QUO_BITS - 1);
        // quotient of 101 or more saturates, so the divide needs only 7 bits
        if (!den_w[16] && (den_w != '0) && ({1'b0, diff} >= den_w)) begin
          pct[ch] <= neg ? (8'd0 - PCT_MAX) : PCT_MAX;
        end
      end
      B_DIV: begin
        if (!trial[23]) begin
          rem <= trial[22:0];
          quo <= {quo[QUO_BITS-2:0], 1'b1};
        end else begin
          quo <= {quo[QUO_BITS-2:0], 1'b0};
        end
        bit_cnt <= bit_cnt - 3'd1;
      end
      B_FIN: begin
        pct[ch] <= neg ? (8'd0 - {1'b0, quo}) : {1'b0, quo};
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[src/servo_pulse_normalizer_frame.sv]
// Top level: configuration registers, front, queue and back of the normalizer.
//
// Usage: one input beat on s_* is one radio tick: three channel timer values in
// s_tdata and the data-good flag in s_tuser. Every tick yields one frame of four
// beats on m_*: header 0x87, steer percent, throttle percent, flags byte; m_tlast
// marks the flags beat. Configuration is written through cfg_we/cfg_index/cfg_data
// while no frame is pending.
// The front converts the timers and updates the startup counter and the switch in
// the accept cycle and pushes the tick into a short queue; s_tready drops only
// when that queue is full. The back works one tick at a time: calibration on the
// first good tick after startup, then clamp, setup and a 7-step restoring divide
// per channel, then 4 beats. It takes no new tick until the last beat of the frame
// is out, and both channels share one divide.
// Reset (rst, synchronous) restores the register defaults, clears calibration,
// the startup count and the switch, and empties the queue and output.
// A stalled receiver holds the current beat; the back waits, the queue fills and
// then the input side stalls.
`timescale 1ns / 1ps
`default_nettype none

module servo_pulse_normalizer_frame
  import spnf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [47:0]            s_tdata,  // steer_timer, throttle_timer, aux_timer
  input  wire logic                   s_tuser,  // data_good
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [7:0]                  m_tdata,  // frame_byte
  output logic                        m_tlast
);

  localparam int unsigned CMD_W = $bits(tick_cmd_t);

  cfg_t       cfg;
  tick_cmd_t  front_cmd;
  tick_cmd_t  back_cmd;
  logic [CMD_W-1:0] back_cmd_bits;
  logic       cmd_push;
  logic       cmd_pop;
  logic       queue_full;
  logic       queue_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_centre   <= PULSE_CENTRE_RST;
      cfg.switch_hyst    <= SWITCH_HYST_RST;
      cfg.endpoint_delta <= ENDPOINT_DELTA_RST;
      cfg.startup_ticks  <= STARTUP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_CENTRE:   cfg.pulse_centre   <= cfg_data;
        REG_SWITCH_HYST:    cfg.switch_hyst    <= cfg_data[7:0];
        REG_ENDPOINT_DELTA: cfg.endpoint_delta <= cfg_data[9:0];
        REG_STARTUP_TICKS:  cfg.startup_ticks  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  spnf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  spnf_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (cmd_pop),
    .pop_data  (back_cmd_bits),
    .not_empty (queue_valid)
  );

  assign back_cmd = tick_cmd_t'(back_cmd_bits);

  spnf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .endpoint_delta (cfg.endpoint_delta),
    .cmd_valid      (queue_valid),
    .cmd            (back_cmd),
    .cmd_pop        (cmd_pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast)
  );

`ifndef SYNTHESIS
  // a frame always opens with the header
  a_frame_head: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (m_tdata == FRAME_HEADER))
    else $error("frame does not start with header");

  // only the switch and startup bits may be set in the flags beat
  a_flags_bits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> ((m_tdata & ~(STARTUP_FLAG | 8'h01)) == 8'h00))
    else $error("flags beat has stray bits");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !(m_tdata[4] && m_tdata[0]))
    else $error("switch reported during startup");

  // percent beats stay within -100..100
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> ((m_tdata == FRAME_HEADER) ||
      (($signed(m_tdata) <= 8'sd100) && ($signed(m_tdata) >= -8'sd100))))
    else $error("percent out of range");
`endif

endmodule

`default_nettype wire
